[hdl/complex_arith_unit_defines.svh]
// Assertion macros for the complex arithmetic unit.
// Each check is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex_arith_unit: same-cycle check failed");
`define CAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex_arith_unit: next-cycle check failed");
`else
`define CAU_ASSERT_NOW(label, ante, cons)
`define CAU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/cau_pkg.sv]
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Control that travels with every item down the pipeline.
  typedef struct packed {
    logic vld;
    op_t  op;
  } ctrl_t;

endpackage

[hdl/cau_prod.sv]
module cau_prod #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  cau_pkg::ctrl_t                ctrl_i,
  input  logic signed [DATA_WIDTH-1:0]  a_re_i,
  input  logic signed [DATA_WIDTH-1:0]  a_im_i,
  input  logic signed [DATA_WIDTH-1:0]  b_re_i,
  input  logic signed [DATA_WIDTH-1:0]  b_im_i,
  output cau_pkg::ctrl_t                ctrl_r,
  output logic signed [2*DATA_WIDTH-1:0] ac_r,
  output logic signed [2*DATA_WIDTH-1:0] bd_r,
  output logic signed [2*DATA_WIDTH-1:0] bc_r,
  output logic signed [2*DATA_WIDTH-1:0] ad_r,
  output logic signed [2*DATA_WIDTH-1:0] cc_r,
  output logic signed [2*DATA_WIDTH-1:0] dd_r,
  output logic signed [DATA_WIDTH:0]    re_as_r,
  output logic signed [DATA_WIDTH:0]    im_as_r
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;

  logic signed [PW-1:0] ac_nxt, bd_nxt, bc_nxt, ad_nxt, cc_nxt, dd_nxt;
  logic signed [W:0]    re_as_nxt, im_as_nxt;
  logic signed [W:0]    a_re_x, a_im_x, b_re_x, b_im_x;

  always_comb begin
    a_re_x = {a_re_i[W-1], a_re_i};
    a_im_x = {a_im_i[W-1], a_im_i};
    b_re_x = {b_re_i[W-1], b_re_i};
    b_im_x = {b_im_i[W-1], b_im_i};
    ac_nxt = PW'(a_re_i) * PW'(b_re_i);
    bd_nxt = PW'(a_im_i) * PW'(b_im_i);
    bc_nxt = PW'(a_im_i) * PW'(b_re_i);
    ad_nxt = PW'(a_re_i) * PW'(b_im_i);
    cc_nxt = PW'(b_re_i) * PW'(b_re_i);
    dd_nxt = PW'(b_im_i) * PW'(b_im_i);
    if (ctrl_i.op == cau_pkg::OP_SUB) begin
      re_as_nxt = a_re_x - b_re_x;
      im_as_nxt = a_im_x - b_im_x;
    end else begin
      re_as_nxt = a_re_x + b_re_x;
      im_as_nxt = a_im_x + b_im_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r    <= ac_nxt;
      bd_r    <= bd_nxt;
      bc_r    <= bc_nxt;
      ad_r    <= ad_nxt;
      cc_r    <= cc_nxt;
      dd_r    <= dd_nxt;
      re_as_r <= re_as_nxt;
      im_as_r <= im_as_nxt;
    end
  end

endmodule

[hdl/cau_comb.sv]
module cau_comb #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  cau_pkg::ctrl_t                 ctrl_i,
  input  logic signed [2*DATA_WIDTH-1:0] ac_i,
  input  logic signed [2*DATA_WIDTH-1:0] bd_i,
  input  logic signed [2*DATA_WIDTH-1:0] bc_i,
  input  logic signed [2*DATA_WIDTH-1:0] ad_i,
  input  logic signed [2*DATA_WIDTH-1:0] cc_i,
  input  logic signed [2*DATA_WIDTH-1:0] dd_i,
  input  logic signed [DATA_WIDTH:0]     re_as_i,
  input  logic signed [DATA_WIDTH:0]     im_as_i,
  output cau_pkg::ctrl_t                 ctrl_r,
  output logic                           neg_re_r,
  output logic                           neg_im_r,
  output logic [2*DATA_WIDTH:0]          mag_re_r,
  output logic [2*DATA_WIDTH:0]          mag_im_r,
  output logic [2*DATA_WIDTH-1:0]        z_r
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;

  logic [SW-1:0] s_mre, s_mim, s_x, s_y, s_are, s_aim;
  logic          neg_re_nxt, neg_im_nxt;
  logic [SW-1:0] mag_re_nxt, mag_im_nxt;
  logic [PW-1:0] z_nxt;

  function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
    return v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

  always_comb begin
    s_mre = {ac_i[PW-1], ac_i} - {bd_i[PW-1], bd_i};
    s_mim = {bc_i[PW-1], bc_i} + {ad_i[PW-1], ad_i};
    s_x   = {ac_i[PW-1], ac_i} + {bd_i[PW-1], bd_i};
    s_y   = {bc_i[PW-1], bc_i} - {ad_i[PW-1], ad_i};
    s_are = {{(SW-W-1){re_as_i[W]}}, re_as_i};
    s_aim = {{(SW-W-1){im_as_i[W]}}, im_as_i};
    z_nxt = PW'(cc_i) + PW'(dd_i);
    case (ctrl_i.op)
      cau_pkg::OP_MUL: begin
        neg_re_nxt = s_mre[SW-1];
        neg_im_nxt = s_mim[SW-1];
        mag_re_nxt = mag_of(s_mre) >> FRAC_BITS;
        mag_im_nxt = mag_of(s_mim) >> FRAC_BITS;
      end
      cau_pkg::OP_DIV: begin
        neg_re_nxt = s_x[SW-1];
        neg_im_nxt = s_y[SW-1];
        mag_re_nxt = mag_of(s_x);
        mag_im_nxt = mag_of(s_y);
      end
      default: begin
        neg_re_nxt = s_are[SW-1];
        neg_im_nxt = s_aim[SW-1];
        mag_re_nxt = mag_of(s_are);
        mag_im_nxt = mag_of(s_aim);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_re_r <= neg_re_nxt;
      neg_im_r <= neg_im_nxt;
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
      z_r      <= z_nxt;
    end
  end

endmodule

[hdl/cau_div_pre.sv]
module cau_div_pre #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  cau_pkg::ctrl_t          ctrl_i,
  input  logic                    neg_re_i,
  input  logic                    neg_im_i,
  input  logic [2*DATA_WIDTH:0]   mag_re_i,
  input  logic [2*DATA_WIDTH:0]   mag_im_i,
  input  logic [2*DATA_WIDTH-1:0] z_i,
  output cau_pkg::ctrl_t          ctrl_r,
  output logic                    neg_re_r,
  output logic                    neg_im_r,
  output logic                    ovf_re_r,
  output logic                    ovf_im_r,
  output logic [2*DATA_WIDTH:0]   r_re_r,
  output logic [2*DATA_WIDTH:0]   r_im_r,
  output logic [DATA_WIDTH-1:0]   q_re_r,
  output logic [DATA_WIDTH-1:0]   q_im_r,
  output logic [2*DATA_WIDTH-1:0] z_r
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int NW = SW + FRAC_BITS;
  localparam int CW = (NW > PW + W) ? NW : PW + W;

  logic [CW-1:0] num_re, num_im, zs, hi_re, hi_im;
  logic          ovf_re_nxt, ovf_im_nxt, is_div;
  logic [SW-1:0] r_re_nxt, r_im_nxt;
  logic [W-1:0]  q_re_nxt, q_im_nxt;

  // A quotient of 2**W or more can only saturate, so it is flagged here and
  // the remaining steps only need to develop W quotient bits.
  always_comb begin
    is_div = (ctrl_i.op == cau_pkg::OP_DIV);
    num_re = CW'(mag_re_i) << FRAC_BITS;
    num_im = CW'(mag_im_i) << FRAC_BITS;
    zs     = CW'(z_i) << W;
    hi_re  = num_re >> W;
    hi_im  = num_im >> W;
    if (is_div) begin
      ovf_re_nxt = (num_re >= zs);
      ovf_im_nxt = (num_im >= zs);
      r_re_nxt   = hi_re[SW-1:0];
      r_im_nxt   = hi_im[SW-1:0];
      q_re_nxt   = num_re[W-1:0];
      q_im_nxt   = num_im[W-1:0];
    end else begin
      ovf_re_nxt = 1'b0;
      ovf_im_nxt = 1'b0;
      r_re_nxt   = mag_re_i;
      r_im_nxt   = mag_im_i;
      q_re_nxt   = '0;
      q_im_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_re_r <= neg_re_i;
      neg_im_r <= neg_im_i;
      ovf_re_r <= ovf_re_nxt;
      ovf_im_r <= ovf_im_nxt;
      r_re_r   <= r_re_nxt;
      r_im_r   <= r_im_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      z_r      <= z_i;
    end
  end

endmodule

[hdl/cau_div_step.sv]
module cau_div_step #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  cau_pkg::ctrl_t          ctrl_i,
  input  logic                    neg_re_i,
  input  logic                    neg_im_i,
  input  logic                    ovf_re_i,
  input  logic                    ovf_im_i,
  input  logic [2*DATA_WIDTH:0]   r_re_i,
  input  logic [2*DATA_WIDTH:0]   r_im_i,
  input  logic [DATA_WIDTH-1:0]   q_re_i,
  input  logic [DATA_WIDTH-1:0]   q_im_i,
  input  logic [2*DATA_WIDTH-1:0] z_i,
  output cau_pkg::ctrl_t          ctrl_r,
  output logic                    neg_re_r,
  output logic                    neg_im_r,
  output logic                    ovf_re_r,
  output logic                    ovf_im_r,
  output logic [2*DATA_WIDTH:0]   r_re_r,
  output logic [2*DATA_WIDTH:0]   r_im_r,
  output logic [DATA_WIDTH-1:0]   q_re_r,
  output logic [DATA_WIDTH-1:0]   q_im_r,
  output logic [2*DATA_WIDTH-1:0] z_r
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = 2 * W + 1;

  logic [RW-1:0] r_re_nxt, r_im_nxt;
  logic [W-1:0]  q_re_nxt, q_im_nxt;

  // One restoring step: the next dividend bit leaves the top of q, the new
  // quotient bit enters at its bottom.
  function automatic logic [RW+W-1:0] step(input logic [RW-1:0] r, input logic [W-1:0] q,
                                           input logic [RW-2:0] z);
    logic [RW-1:0] t;
    logic          qb;
    t  = {r[RW-2:0], q[W-1]};
    qb = (t >= {1'b0, z});
    if (qb) begin
      t = t - {1'b0, z};
    end
    return {t, q[W-2:0], qb};
  endfunction

  always_comb begin
    if (ctrl_i.op == cau_pkg::OP_DIV) begin
      {r_re_nxt, q_re_nxt} = step(r_re_i, q_re_i, z_i);
      {r_im_nxt, q_im_nxt} = step(r_im_i, q_im_i, z_i);
    end else begin
      r_re_nxt = r_re_i;
      r_im_nxt = r_im_i;
      q_re_nxt = q_re_i;
      q_im_nxt = q_im_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_re_r <= neg_re_i;
      neg_im_r <= neg_im_i;
      ovf_re_r <= ovf_re_i;
      ovf_im_r <= ovf_im_i;
      r_re_r   <= r_re_nxt;
      r_im_r   <= r_im_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      z_r      <= z_i;
    end
  end

endmodule

[hdl/complex_arith_unit.sv]
// Complex arithmetic unit: add, subtract, multiply and divide of two complex
// operands in signed fixed point (Q16.16 by default).
// Input channel: in_tdata carries the operands, in_tuser the operation code.
// An item is taken on a clock edge where in_tvalid and in_tready are high.
// Result channel: out_tdata carries the result parts, out_tuser the status
// (ok, divide by zero, overflow with saturation).
// Pipeline stages, in order: one stage forms the six products, one the sums,
// one prepares the division, DATA_WIDTH stages each develop one quotient bit
// of both parts in parallel, and the last stage saturates into the output
// register. Items of every operation flow through the same stages, so order
// is kept. Throughput is one item per cycle while out_tready does not stall
// the output; the divider is fully unrolled.
// Every stage holds its own valid bit and loads whenever it is empty or its
// successor moves on, so a stalled receiver only backs the pipeline up as it
// fills; empty stages keep accepting until all are full.
// Reset clears all valid bits; no item is in flight afterward.
`include "complex_arith_unit_defines.svh"
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  localparam int IDW = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int ODW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // Fields from bit 0 up: a_real, a_imag, b_real, b_imag, zero fill.
  input  logic [IDW-1:0] in_tdata,
  // Fields from bit 0 up: op.
  input  logic [1:0]     in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  // Fields from bit 0 up: res_real, res_imag, zero fill.
  output logic [ODW-1:0] out_tdata,
  // Fields from bit 0 up: status.
  output logic [1:0]     out_tuser
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int NS = W + 4;
  localparam logic [W-1:0] RES_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] RES_MIN = {1'b1, {(W-1){1'b0}}};

  // Stage load enables: stage k loads when empty or when stage k+1 loads.
  logic [NS-1:0] vld, en;

  cau_pkg::ctrl_t in_ctrl;
  assign in_ctrl = '{vld: in_tvalid, op: cau_pkg::op_t'(in_tuser)};
  assign in_tready = en[0];

  // Product stage.
  cau_pkg::ctrl_t       p_ctrl;
  logic signed [PW-1:0] p_ac, p_bd, p_bc, p_ad, p_cc, p_dd;
  logic signed [W:0]    p_re_as, p_im_as;

  cau_prod #(.DATA_WIDTH(W)) u_prod (
    .clk(clk), .rst_n(rst_n), .en(en[0]), .ctrl_i(in_ctrl),
    .a_re_i(in_tdata[W-1:0]), .a_im_i(in_tdata[2*W-1:W]),
    .b_re_i(in_tdata[3*W-1:2*W]), .b_im_i(in_tdata[4*W-1:3*W]),
    .ctrl_r(p_ctrl), .ac_r(p_ac), .bd_r(p_bd), .bc_r(p_bc), .ad_r(p_ad),
    .cc_r(p_cc), .dd_r(p_dd), .re_as_r(p_re_as), .im_as_r(p_im_as)
  );

  // Sum and sign/magnitude stage.
  cau_pkg::ctrl_t c_ctrl;
  logic           c_neg_re, c_neg_im;
  logic [SW-1:0]  c_mag_re, c_mag_im;
  logic [PW-1:0]  c_z;

  cau_comb #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_comb (
    .clk(clk), .rst_n(rst_n), .en(en[1]), .ctrl_i(p_ctrl),
    .ac_i(p_ac), .bd_i(p_bd), .bc_i(p_bc), .ad_i(p_ad), .cc_i(p_cc), .dd_i(p_dd),
    .re_as_i(p_re_as), .im_as_i(p_im_as),
    .ctrl_r(c_ctrl), .neg_re_r(c_neg_re), .neg_im_r(c_neg_im),
    .mag_re_r(c_mag_re), .mag_im_r(c_mag_im), .z_r(c_z)
  );

  // Division chain: index 0 is the preparation stage, index k+1 is step k.
  cau_pkg::ctrl_t d_ctrl   [W+1];
  logic           d_neg_re [W+1];
  logic           d_neg_im [W+1];
  logic           d_ovf_re [W+1];
  logic           d_ovf_im [W+1];
  logic [SW-1:0]  d_r_re   [W+1];
  logic [SW-1:0]  d_r_im   [W+1];
  logic [W-1:0]   d_q_re   [W+1];
  logic [W-1:0]   d_q_im   [W+1];
  logic [PW-1:0]  d_z      [W+1];

  cau_div_pre #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_pre (
    .clk(clk), .rst_n(rst_n), .en(en[2]), .ctrl_i(c_ctrl),
    .neg_re_i(c_neg_re), .neg_im_i(c_neg_im), .mag_re_i(c_mag_re), .mag_im_i(c_mag_im),
    .z_i(c_z),
    .ctrl_r(d_ctrl[0]), .neg_re_r(d_neg_re[0]), .neg_im_r(d_neg_im[0]),
    .ovf_re_r(d_ovf_re[0]), .ovf_im_r(d_ovf_im[0]), .r_re_r(d_r_re[0]),
    .r_im_r(d_r_im[0]), .q_re_r(d_q_re[0]), .q_im_r(d_q_im[0]), .z_r(d_z[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_step
    cau_div_step #(.DATA_WIDTH(W)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en[k+3]), .ctrl_i(d_ctrl[k]),
      .neg_re_i(d_neg_re[k]), .neg_im_i(d_neg_im[k]),
      .ovf_re_i(d_ovf_re[k]), .ovf_im_i(d_ovf_im[k]),
      .r_re_i(d_r_re[k]), .r_im_i(d_r_im[k]), .q_re_i(d_q_re[k]), .q_im_i(d_q_im[k]),
      .z_i(d_z[k]),
      .ctrl_r(d_ctrl[k+1]), .neg_re_r(d_neg_re[k+1]), .neg_im_r(d_neg_im[k+1]),
      .ovf_re_r(d_ovf_re[k+1]), .ovf_im_r(d_ovf_im[k+1]),
      .r_re_r(d_r_re[k+1]), .r_im_r(d_r_im[k+1]),
      .q_re_r(d_q_re[k+1]), .q_im_r(d_q_im[k+1]), .z_r(d_z[k+1])
    );
  end

  // Valid bits of all stages, in order, and the enable chain.
  assign vld[0] = p_ctrl.vld;
  assign vld[1] = c_ctrl.vld;
  for (genvar k = 0; k <= W; k++) begin : g_vld
    assign vld[k+2] = d_ctrl[k].vld;
  end
  assign vld[NS-1] = out_tvalid;

  assign en[NS-1] = !vld[NS-1] || out_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  // Output stage: choose the magnitude, saturate and attach the status.
  function automatic logic [W:0] saturate(input logic neg, input logic [SW-1:0] mag);
    logic [SW-1:0] lim;
    logic [SW-1:0] twos;
    lim  = SW'(1) << (W - 1);
    twos = ~mag + SW'(1);
    if (!neg) begin
      return (mag > lim - SW'(1)) ? {1'b1, RES_MAX} : {1'b0, mag[W-1:0]};
    end
    return (mag > lim) ? {1'b1, RES_MIN} : {1'b0, twos[W-1:0]};
  endfunction

  logic [SW-1:0]    f_mag_re, f_mag_im;
  logic [W:0]       f_sat_re, f_sat_im;
  logic [W-1:0]     res_re_nxt, res_im_nxt;
  cau_pkg::status_t status_nxt;
  logic [W-1:0]     res_re_r, res_im_r;
  cau_pkg::status_t status_r;

  always_comb begin
    if (d_ctrl[W].op == cau_pkg::OP_DIV) begin
      f_mag_re = d_ovf_re[W] ? {SW{1'b1}} : SW'(d_q_re[W]);
      f_mag_im = d_ovf_im[W] ? {SW{1'b1}} : SW'(d_q_im[W]);
    end else begin
      f_mag_re = d_r_re[W];
      f_mag_im = d_r_im[W];
    end
    f_sat_re = saturate(d_neg_re[W], f_mag_re);
    f_sat_im = saturate(d_neg_im[W], f_mag_im);
    if (d_ctrl[W].op == cau_pkg::OP_DIV && d_z[W] == '0) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = cau_pkg::ST_DIV_ZERO;
    end else begin
      res_re_nxt = f_sat_re[W-1:0];
      res_im_nxt = f_sat_im[W-1:0];
      status_nxt = (f_sat_re[W] || f_sat_im[W]) ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en[NS-1]) begin
      out_tvalid <= d_ctrl[W].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tdata = ODW'({res_im_r, res_re_r});
  assign out_tuser = status_r;

  // A division by zero always delivers a zero result.
  `CAU_ASSERT_NOW(a_div_zero_clears, out_tvalid && status_r == cau_pkg::ST_DIV_ZERO, res_re_r == '0 && res_im_r == '0)
  // An overflow status means at least one part sits at a bound.
  `CAU_ASSERT_NOW(a_ovf_saturated, out_tvalid && status_r == cau_pkg::ST_OVERFLOW, res_re_r == RES_MAX || res_re_r == RES_MIN || res_im_r == RES_MAX || res_im_r == RES_MIN)
  // The input side is only refused when every stage is full and the output is stalled.
  `CAU_ASSERT_NOW(a_refuse_only_full, !in_tready, out_tvalid && !out_tready && (&vld))

endmodule

[tb/tb_complex_arith_unit.sv]
`timescale 1ns / 100ps

// Testbench for the complex arithmetic unit. Items are driven on the input
// stream with random gaps, results are taken with random back-pressure, and
// every result is compared against a predictor kept in this file.
module tb_complex_arith_unit;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = DW + 4;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DW-1:0]     im;
    logic [DW-1:0]     re;
    cau_pkg::status_t  st;
  } cplx_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [4*DW-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [2*DW-1:0] out_tdata;
  logic [1:0] out_tuser;

  // Results still owed by the block, oldest first.
  cplx_result_t pending_results[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  longint cycles;

  complex_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Clamp an exact wide value into the signed result range.
  function automatic logic [DW-1:0] saturate(input logic signed [199:0] v,
                                             inout bit ovf);
    logic signed [199:0] hi;
    logic signed [199:0] lo;
    begin
      hi = (200'sd1 <<< (DW - 1)) - 1;
      lo = -(200'sd1 <<< (DW - 1));
      if (v > hi) begin
        ovf = 1'b1;
        return hi[DW-1:0];
      end
      if (v < lo) begin
        ovf = 1'b1;
        return lo[DW-1:0];
      end
      return v[DW-1:0];
    end
  endfunction

  // Signed division truncated toward zero, done on magnitudes.
  function automatic logic signed [199:0] div_trunc(input logic signed [199:0] n,
                                                    input logic signed [199:0] d);
    logic [199:0] q;
    begin
      q = (n < 0 ? -n : n) / d;
      return (n < 0) ? -$signed(q) : $signed(q);
    end
  endfunction

  // Shift right truncating toward zero.
  function automatic logic signed [199:0] shr_trunc(input logic signed [199:0] n);
    logic [199:0] m;
    begin
      m = (n < 0 ? -n : n) >> FB;
      return (n < 0) ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic cplx_result_t compute_complex(input cau_pkg::op_t op,
      input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
      input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
    logic signed [199:0] a, b, c, d, re, im, z;
    bit ovf;
    cplx_result_t r;
    begin
      a = ar; b = ai; c = br; d = bi;
      ovf = 1'b0;
      case (op)
        cau_pkg::OP_ADD: begin
          re = a + c;
          im = b + d;
        end
        cau_pkg::OP_SUB: begin
          re = a - c;
          im = b - d;
        end
        cau_pkg::OP_MUL: begin
          re = shr_trunc(a * c - b * d);
          im = shr_trunc(b * c + a * d);
        end
        default: begin
          z = c * c + d * d;
          if (z == 0) begin
            r.re = '0;
            r.im = '0;
            r.st = cau_pkg::ST_DIV_ZERO;
            return r;
          end
          re = div_trunc((a * c + b * d) <<< FB, z);
          im = div_trunc((b * c - a * d) <<< FB, z);
        end
      endcase
      r.re = saturate(re, ovf);
      r.im = saturate(im, ovf);
      r.st = ovf ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK;
      return r;
    end
  endfunction

  // Offer one item, possibly after a random gap, and wait until it is taken.
  // The valid line stays high after acceptance so that a following item can
  // go out in the very next cycle; idle cycles and drain() lower it.
  task automatic send_item(input cau_pkg::op_t op, input logic [DW-1:0] ar,
      input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser <= op;
      in_tdata <= {bi, br, ai, ar};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      pending_results.push_back(compute_complex(op, ar, ai, br, bi));
    end
  endtask

  // Random operand: often an extreme, sometimes small, otherwise any value.
  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $signed($urandom_range(2 ** 20)) - (2 ** 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    begin
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    logic [DW-1:0] ext[4];
    cau_pkg::op_t op;
    begin
      ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_ffff};
      for (int k = 0; k < 4; k++) begin
        op = cau_pkg::op_t'(k);
        send_item(op, ext[0], ext[0], ext[1], ext[1]);
        send_item(op, ext[1], ext[1], ext[0], ext[0]);
        send_item(op, ext[1], ext[0], ext[1], ext[1]);
        send_item(op, ext[2], ext[3], ext[2], ext[2]);
      end
      // Division by a zero divisor, and a tiny divisor that saturates.
      send_item(cau_pkg::OP_DIV, ext[2], ext[2], '0, '0);
      send_item(cau_pkg::OP_DIV, ext[0], ext[1], '0, '0);
      send_item(cau_pkg::OP_DIV, ext[0], ext[0], 32'h1, '0);
      send_item(cau_pkg::OP_DIV, '0, '0, 32'h1, 32'h1);
      send_item(cau_pkg::OP_MUL, 32'h0001_8000, 32'hfffe_8000, 32'h0000_4000,
                32'hffff_c000);
    end
  endtask

  task automatic test_random(input int count);
    begin
      for (int n = 0; n < count; n++) begin
        send_item(cau_pkg::op_t'($urandom_range(3)), rand_operand(), rand_operand(),
                  ($urandom_range(15) == 0) ? '0 : rand_operand(),
                  ($urandom_range(15) == 0) ? '0 : rand_operand());
      end
    end
  endtask

  // Receiver stalls for a long stretch while items keep coming, so the
  // pipeline fills and must stall its input.
  task automatic test_backpressure();
    begin
      recv_hold = 1'b1;
      fork
        test_random(60);
        begin
          repeat (200) @(posedge clk);
          recv_hold = 1'b0;
        end
      join
      drain();
    end
  endtask

  // Receiver: random stalls, held off entirely while recv_hold is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    cplx_result_t want;
    cplx_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.re = out_tdata[DW-1:0];
      got.im = out_tdata[2*DW-1:DW];
      got.st = cau_pkg::status_t'(out_tuser);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: re %h/%h im %h/%h status %0d/%0d (expected/actual)",
                     want.re, got.re, want.im, got.im, want.st, got.st);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    recv_hold = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    send_idle_pct = 11;
    recv_idle_pct = 48;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(220);
    // The sender pauses here until every outstanding result is back.
    drain();
    send_idle_pct = 48;
    recv_idle_pct = 11;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220);
    test_backpressure();

    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_prod.sv
hdl/cau_comb.sv
hdl/cau_div_pre.sv
hdl/cau_div_step.sv
hdl/complex_arith_unit.sv
tb/tb_complex_arith_unit.sv
